// File: rtl/core/tcgp_pkg.sv
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared constants, types and the glyph decode for the text cursor glyph placer.
// ----------------------------------------------------------------------------
package tcgp_pkg;

   localparam int COLUMNS     = 40;
   localparam int ROWS        = 25;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 5;
   localparam int CNT_W       = 16;
   localparam int IDX_W       = 6;
   localparam int ADDR_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [ADDR_W-1:0] GLYPH_BYTES = 32'h0000_004B;
   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
   localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic [CSR_IDX_W-1:0] CSR_INK_COLOR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_FLAGS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_BASE = 2'd2;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             opq;
   } glyph_type;

   // One queue entry: everything the back end needs to emit an item's results.
   typedef struct packed {
      logic             has_draw;
      logic [COL_W-1:0] draw_col;
      logic [ROW_W-1:0] draw_row;
      logic [IDX_W-1:0] draw_idx;
      logic             draw_opq;
      logic             has_report;
      logic [COL_W-1:0] end_col;
      logic [ROW_W-1:0] end_row;
      logic [CNT_W-1:0] count;
   } cmd_type;

   function automatic glyph_type glyph_lookup(input logic [7:0] c);
      glyph_type g;
      g = '{valid: 1'b1, idx: '0, opq: 1'b0};
      if (c >= 8'h41 && c <= 8'h5A) begin
         g.idx = IDX_W'(c - 8'h40);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         g.idx = IDX_W'(c - 8'h60);
      end else if (c >= 8'h30 && c <= 8'h3A) begin
         g.idx = IDX_W'(c - 8'h30 + 8'd27);
      end else begin
         case (c)
            CHAR_SPACE: begin
               g.opq = 1'b1;
            end
            8'h2E: g.idx = 6'd39;
            8'h2F: g.idx = 6'd41;
            8'h3E: g.idx = 6'd40;
            8'h27: g.idx = 6'd38;
            8'h2C: g.idx = 6'd43;
            8'h7C: g.idx = 6'd42;
            default: g.valid = 1'b0;
         endcase
      end
      return g;
   endfunction

endpackage

// File: rtl/core/tcgp_front.sv
// ----------------------------------------------------------------------------
// tcgp_front
// Accepts characters, tracks cursor, count and stop flag, and queues commands.
// ----------------------------------------------------------------------------
module tcgp_front
   import tcgp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_char_code,
   input  logic [COL_W-1:0] req_start_col,
   input  logic [ROW_W-1:0] req_start_row,
   input  logic             req_first_char,
   input  logic             req_last_char,
   input  logic             queue_full,
   output logic             push,
   output cmd_type          push_cmd
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             stopped_ff, stopped_in;

   logic             accept;
   logic [COL_W-1:0] col_s;
   logic [ROW_W-1:0] row_s;
   logic [CNT_W-1:0] count_s;
   logic             stop_s;
   logic             bump;
   glyph_type        glyph;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign glyph     = glyph_lookup(req_char_code);

   always_comb begin
      col_s   = req_first_char ? req_start_col : col_ff;
      row_s   = req_first_char ? req_start_row : row_ff;
      count_s = req_first_char ? '0 : count_ff;
      stop_s  = req_first_char ? !(req_start_col < COL_W'(COLUMNS) &&
                                   req_start_row < ROW_W'(ROWS))
                               : stopped_ff;

      col_in     = col_s;
      row_in     = row_s;
      stopped_in = stop_s;
      bump       = 1'b0;
      push_cmd   = '0;

      if (!stop_s) begin
         if (req_char_code == CHAR_NUL) begin
            stopped_in = 1'b1;
         end else if (req_char_code != CHAR_BACKSPACE) begin
            push_cmd.has_draw = glyph.valid;
            push_cmd.draw_col = col_s;
            push_cmd.draw_row = row_s;
            push_cmd.draw_idx = glyph.idx;
            push_cmd.draw_opq = glyph.opq;
            if (col_s < LAST_COL && req_char_code != CHAR_NEWLINE) begin
               col_in = col_s + 1'b1;
               bump   = 1'b1;
            end else if (row_s < LAST_ROW) begin
               col_in = '0;
               row_in = row_s + 1'b1;
               bump   = 1'b1;
            end else begin
               stopped_in = 1'b1;
            end
         end else begin
            if (col_s != '0) begin
               col_in = col_s - 1'b1;
               bump   = 1'b1;
            end else if (row_s != '0) begin
               col_in = LAST_COL;
               row_in = row_s - 1'b1;
               bump   = 1'b1;
            end else begin
               stopped_in = 1'b1;
            end
            push_cmd.has_draw = bump;
            push_cmd.draw_col = col_in;
            push_cmd.draw_row = row_in;
            push_cmd.draw_idx = '0;
            push_cmd.draw_opq = 1'b1;
         end
      end

      count_in = (bump && count_s != COUNT_MAX) ? count_s + 1'b1 : count_s;

      push_cmd.has_report = req_last_char;
      push_cmd.end_col    = col_in;
      push_cmd.end_row    = row_in;
      push_cmd.count      = count_in;
      push = accept && (push_cmd.has_draw || push_cmd.has_report);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: rtl/core/tcgp_queue.sv
// ----------------------------------------------------------------------------
// tcgp_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module tcgp_queue
   import tcgp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              do_pop;

   assign full       = fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      fill_in = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/tcgp_back.sv
// ----------------------------------------------------------------------------
// tcgp_back
// Turns queued commands into glyph draw and end-of-string result items.
// ----------------------------------------------------------------------------
module tcgp_back
   import tcgp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] glyph_base,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [8:0]        rsp_pixel_x,
   output logic [7:0]        rsp_pixel_y,
   output logic [ADDR_W-1:0] rsp_glyph_addr,
   output logic              rsp_opaque_override,
   output logic [COL_W-1:0]  rsp_end_col,
   output logic [ROW_W-1:0]  rsp_end_row,
   output logic [CNT_W-1:0]  rsp_count,
   output logic              rsp_last
);

   logic              valid_ff;
   logic              draw_done_ff, draw_done_in;
   logic              load;
   logic              emit_draw;
   logic              kind_ff, kind_in;
   logic [8:0]        px_ff, px_in;
   logic [7:0]        py_ff, py_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              opq_ff, opq_in;
   logic [COL_W-1:0]  ecol_ff, ecol_in;
   logic [ROW_W-1:0]  erow_ff, erow_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              last_ff, last_in;

   assign load      = head_valid && (!valid_ff || !rsp_stall);
   assign emit_draw = head_cmd.has_draw && !draw_done_ff;

   always_comb begin
      kind_in = KIND_REPORT;
      px_in   = '0;
      py_in   = '0;
      addr_in = '0;
      opq_in  = 1'b0;
      ecol_in = '0;
      erow_in = '0;
      cnt_in  = '0;
      last_in = 1'b1;
      if (emit_draw) begin
         kind_in = KIND_DRAW;
         px_in   = {head_cmd.draw_col, 3'b000};
         py_in   = {head_cmd.draw_row, 3'b000};
         addr_in = glyph_base + GLYPH_BYTES * ADDR_W'(head_cmd.draw_idx);
         opq_in  = head_cmd.draw_opq;
         last_in = !head_cmd.has_report;
      end else begin
         ecol_in = head_cmd.end_col;
         erow_in = head_cmd.end_row;
         cnt_in  = head_cmd.count;
      end
      pop          = load && last_in;
      draw_done_in = load ? !last_in : draw_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         draw_done_ff <= 1'b0;
      end else begin
         draw_done_ff <= draw_done_in;
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         addr_ff <= addr_in;
         opq_ff  <= opq_in;
         ecol_ff <= ecol_in;
         erow_ff <= erow_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_pixel_x         = px_ff;
   assign rsp_pixel_y         = py_ff;
   assign rsp_glyph_addr      = addr_ff;
   assign rsp_opaque_override = opq_ff;
   assign rsp_end_col         = ecol_ff;
   assign rsp_end_row         = erow_ff;
   assign rsp_count           = cnt_ff;
   assign rsp_last            = last_ff;

endmodule

// File: rtl/core/text_cursor_glyph_placer_core.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_placer_core
// Places a character stream on a 40 by 25 text screen as glyph draw items.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Moves
// req_      in         req_valid/req_stall   one character item
// rsp_      out        rsp_valid/rsp_stall   one draw or end-of-string item
// csr_      in         csr_write             one register write
//
// The front end takes one character per cycle while req_stall is low and
// updates the cursor at once. The back end emits one result item per cycle
// while rsp_stall is low; a character with both a draw and a report gives two items.
// A four-entry queue separates the two; req_stall is high only when it is full.
// Reset clears cursor, count, stop flag, queue and glyph base.
// The ink color and draw flag registers are accepted but drive no output.
// ----------------------------------------------------------------------------
module text_cursor_glyph_placer_core
   import tcgp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_char_code,
   input  logic [COL_W-1:0]     req_start_col,
   input  logic [ROW_W-1:0]     req_start_row,
   input  logic                 req_first_char,
   input  logic                 req_last_char,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [8:0]           rsp_pixel_x,
   output logic [7:0]           rsp_pixel_y,
   output logic [ADDR_W-1:0]    rsp_glyph_addr,
   output logic                 rsp_opaque_override,
   output logic [COL_W-1:0]     rsp_end_col,
   output logic [ROW_W-1:0]     rsp_end_row,
   output logic [CNT_W-1:0]     rsp_count,
   output logic                 rsp_last
);

   logic [ADDR_W-1:0] glyph_base_ff;
   logic              push, pop, queue_full, head_valid;
   cmd_type           push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_base_ff <= '0;
      end else if (csr_write && csr_index == CSR_GLYPH_BASE) begin
         glyph_base_ff <= csr_data;
      end
   end

   tcgp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_start_col  (req_start_col),
      .req_start_row  (req_start_row),
      .req_first_char (req_first_char),
      .req_last_char  (req_last_char),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   tcgp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tcgp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .glyph_base          (glyph_base_ff),
      .head_valid          (head_valid),
      .head_cmd            (head_cmd),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_glyph_addr      (rsp_glyph_addr),
      .rsp_opaque_override (rsp_opaque_override),
      .rsp_end_col         (rsp_end_col),
      .rsp_end_row         (rsp_end_row),
      .rsp_count           (rsp_count),
      .rsp_last            (rsp_last)
   );

endmodule
